// ===== rtl/msne_pkg.sv =====
// Shared types and constants for the song sequence decoder.
`timescale 1ns / 1ps
package msne_pkg;
  localparam logic [7:0] NoteOffset = 8'd21;
  localparam logic [7:0] MultReset = 8'd6;
  localparam logic [7:0] EndCode = 8'hFE;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_CHAN  = 6'b000010,
    PH_NOTE  = 6'b000100,
    PH_CMD   = 6'b001000,
    PH_ARG   = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  // Controller state, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } ctrl_state_t;

  // Command decoded from the current byte.
  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_PLAY = 3'd1,
    CMD_OFF  = 3'd2,
    CMD_INST = 3'd3,
    CMD_ROW  = 3'd4,
    CMD_END  = 3'd5
  } cmd_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_byte;   // register the accepted byte and decode it
    logic exec;        // apply the decoded command to the track state
    logic flush_step;  // advance the end-flush scan by one track
    logic flush_init;  // start the end-flush scan at track 0
    logic out_load;    // load the output register from the event
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic   is_cmd;     // byte arrives in command phase, not start
    cmd_t   cmd;
    logic   hit;        // play or off finishes a sounding note
    logic   flush_hit;  // scanned track sounds
    logic   flush_more; // a sounding track lies after the scan pointer
    logic   flush_last_track;
  } dp_status_t;
endpackage

// ===== rtl/music_sequence_to_note_events_unit.sv =====
// Top level of the song sequence decoder.
`timescale 1ns / 1ps
// Decodes song bytes into finished note events. Each byte is first registered
// and decoded, with the slot table read; then the track registers are updated
// and, when a note ends, the output register is loaded; that update repeats
// while a full output register is stalled. The end command then scans tracks
// from 0, one per cycle, up to the last sounding track (at most TRACKS tracks),
// and emits one event per sounding track; a stalled output holds the scan.
// row_tick_multiplier is written through cfg_we/cfg_wdata; write it only while idle,
// which the block itself does not enforce.
module music_sequence_to_note_events_unit #(
  parameter int TRACKS = 16,
  parameter int NOTE_SLOTS = 256,
  parameter int TICK_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // song_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // track, note_channel, program_change, instrument, note, delay_ticks, length_ticks
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tuser,  // end_of_song
  output logic        m_axis_tlast
);
  msne_pkg::dp_cmd_t    dcmd;
  msne_pkg::dp_status_t dstat;
  logic ol;

  msne_controller u_ctrl (
    .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .status(dstat), .cmd(dcmd), .out_last(ol)
  );

  msne_datapath #(.TRACKS(TRACKS), .NOTE_SLOTS(NOTE_SLOTS), .TICK_BITS(TICK_BITS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_byte(s_axis_tdata), .in_start(s_axis_tuser), .cmd(dcmd), .out_last_in(ol),
    .status(dstat), .out_data(m_axis_tdata), .out_user(m_axis_tuser),
    .out_last(m_axis_tlast)
  );
endmodule

// ===== rtl/msne_datapath.sv =====
// Datapath: slot table, per-track state, event assembly and output register.
`timescale 1ns / 1ps
module msne_datapath #(
  parameter int TRACKS = 16,
  parameter int NOTE_SLOTS = 256,
  parameter int TICK_BITS = 28
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic [7:0]            in_byte,
  input  logic                  in_start,
  input  msne_pkg::dp_cmd_t     cmd,
  input  logic                  out_last_in,
  output msne_pkg::dp_status_t  status,
  output logic [87:0]           out_data,
  output logic                  out_user,
  output logic                  out_last
);
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int SW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  localparam logic [TICK_BITS-1:0] TickMax = {TICK_BITS{1'b1}};

  logic [7:0] mult;
  msne_pkg::phase_t phase, phase_next;
  logic [7:0] slot_count;
  logic [8:0] load_index;
  logic [3:0] inst_target;
  logic [7:0] byte_r;

  logic [3:0] slot_channel [NOTE_SLOTS];
  logic [7:0] slot_note [NOTE_SLOTS];
  logic [3:0] rd_chan;
  logic [7:0] rd_note;
  logic       rd_valid;

  logic [TRACKS-1:0] active, sounding, pending;
  logic [7:0] held_note [TRACKS];
  logic [TICK_BITS-1:0] held_len [TRACKS];
  logic [TICK_BITS-1:0] rest [TRACKS];
  logic [7:0] instr [TRACKS];

  logic [TICK_BITS-1:0] add_r;
  logic [TW-1:0] scan;
  msne_pkg::cmd_t dcmd, cmd_r;
  logic [8:0] n9, b9;
  logic [8:0] rel;
  logic [7:0] row_units;
  logic [15:0] row_add;
  logic       flush_more;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) mult <= msne_pkg::MultReset;
    else if (cfg_we) mult <= cfg_wdata;
  end

  // Decode byte against the command ranges.
  always_comb begin
    n9 = {1'b0, slot_count};
    b9 = {1'b0, in_byte};
    rel = b9 - n9;
    if (b9 < n9) dcmd = msne_pkg::CMD_PLAY;
    else if (rel < 9'd16) dcmd = msne_pkg::CMD_OFF;
    else if (rel < 9'd32) dcmd = msne_pkg::CMD_INST;
    else if (in_byte < msne_pkg::EndCode) dcmd = msne_pkg::CMD_ROW;
    else dcmd = msne_pkg::CMD_END;
  end

  // Row time ticks: units times multiplier, at most 221 * 255.
  assign row_units = in_byte - slot_count - 8'd32;
  assign row_add = {8'd0, row_units} * {8'd0, mult};

  // Parser and table loading on each accepted byte.
  always_comb begin
    phase_next = phase;
    if (in_start || phase == msne_pkg::PH_COUNT)
      phase_next = (in_byte == 8'd0) ? msne_pkg::PH_CMD : msne_pkg::PH_CHAN;
    else begin
      unique case (phase)
        msne_pkg::PH_CHAN, msne_pkg::PH_NOTE: begin
          if (load_index + 9'd1 >= {1'b0, slot_count})
            phase_next = (phase == msne_pkg::PH_CHAN) ? msne_pkg::PH_NOTE
                                                      : msne_pkg::PH_CMD;
        end
        msne_pkg::PH_ARG: phase_next = msne_pkg::PH_CMD;
        msne_pkg::PH_CMD: begin
          if (dcmd == msne_pkg::CMD_INST) phase_next = msne_pkg::PH_ARG;
          else if (dcmd == msne_pkg::CMD_END) phase_next = msne_pkg::PH_DONE;
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= msne_pkg::PH_COUNT;
      slot_count <= '0;
      load_index <= '0;
      inst_target <= '0;
      cmd_r <= msne_pkg::CMD_NONE;
    end else if (cmd.load_byte) begin
      phase <= phase_next;
      byte_r <= in_byte;
      cmd_r <= (!in_start && phase == msne_pkg::PH_CMD) ? dcmd : msne_pkg::CMD_NONE;
      if (in_start || phase == msne_pkg::PH_COUNT) begin
        slot_count <= in_byte;
        load_index <= '0;
        inst_target <= in_start ? 4'd0 : inst_target;
      end else if (phase == msne_pkg::PH_CHAN || phase == msne_pkg::PH_NOTE) begin
        load_index <= (load_index + 9'd1 >= {1'b0, slot_count}) ? 9'd0
                                                               : load_index + 9'd1;
      end else if (phase == msne_pkg::PH_CMD && dcmd == msne_pkg::CMD_INST) begin
        inst_target <= rel[3:0];
      end
    end
  end

  // Slot table memory with registered read, captured with the accepted byte.
  always_ff @(posedge clk) begin
    if (cmd.load_byte && !in_start && load_index < NOTE_SLOTS) begin
      if (phase == msne_pkg::PH_CHAN) slot_channel[load_index[SW-1:0]] <= in_byte[3:0];
      if (phase == msne_pkg::PH_NOTE) slot_note[load_index[SW-1:0]] <= in_byte;
    end
    if (cmd.load_byte) begin
      rd_chan <= slot_channel[in_byte[SW-1:0]];
      rd_note <= slot_note[in_byte[SW-1:0]];
      rd_valid <= {1'b0, in_byte} < NOTE_SLOTS;
      add_r <= TICK_BITS'(row_add);
    end
  end

  // Target track of the command in flight.
  logic [3:0] tgt;
  logic       tgt_ok;
  logic [7:0] play_note;
  always_comb begin
    play_note = rd_valid ? rd_note : 8'd0;
    if (cmd_r == msne_pkg::CMD_PLAY) tgt = rd_valid ? rd_chan : 4'd0;
    else tgt = 4'(byte_r - slot_count);
    tgt_ok = {1'b0, tgt} < 5'(TRACKS);
  end

  // Flush scan lookahead.
  always_comb begin
    flush_more = 1'b0;
    for (int i = 0; i < TRACKS; i++)
      if (i > int'(scan) && sounding[i]) flush_more = 1'b1;
  end

  logic [3:0] ev_t;
  assign ev_t = cmd.flush_step ? 4'(scan) : tgt;

  assign status.is_cmd = cmd_r != msne_pkg::CMD_NONE;
  assign status.cmd = cmd_r;
  assign status.hit = tgt_ok && sounding[tgt[TW-1:0]];
  assign status.flush_hit = sounding[scan];
  assign status.flush_more = flush_more;
  assign status.flush_last_track = int'(scan) == TRACKS - 1;

  // Track state updates.
  always_ff @(posedge clk) begin
    if (rst || (cmd.load_byte && in_start)) begin
      active <= '0;
      sounding <= '0;
      pending <= '1;
      for (int i = 0; i < TRACKS; i++) begin
        held_note[i] <= '0;
        held_len[i] <= '0;
        rest[i] <= '0;
        instr[i] <= '0;
      end
      scan <= '0;
    end else begin
      if (cmd.load_byte && phase == msne_pkg::PH_CHAN && {1'b0, in_byte[3:0]} < 5'(TRACKS))
        active[in_byte[TW-1:0]] <= 1'b1;
      if (cmd.load_byte && phase == msne_pkg::PH_ARG && {1'b0, inst_target} < 5'(TRACKS)
          && instr[inst_target[TW-1:0]] != in_byte) begin
        instr[inst_target[TW-1:0]] <= in_byte;
        pending[inst_target[TW-1:0]] <= 1'b1;
      end
      // A play that ends a note keeps its track sounding.
      if (cmd.out_load) begin
        pending[ev_t[TW-1:0]] <= 1'b0;
        rest[ev_t[TW-1:0]] <= '0;
        if (!(cmd.exec && cmd_r == msne_pkg::CMD_PLAY))
          sounding[ev_t[TW-1:0]] <= 1'b0;
      end
      if (cmd.exec && cmd_r == msne_pkg::CMD_PLAY && tgt_ok) begin
        held_note[tgt[TW-1:0]] <= play_note + msne_pkg::NoteOffset;
        sounding[tgt[TW-1:0]] <= 1'b1;
        held_len[tgt[TW-1:0]] <= '0;
      end
      if (cmd.exec && cmd_r == msne_pkg::CMD_ROW) begin
        for (int i = 0; i < TRACKS; i++) begin
          if (active[i]) begin
            if (sounding[i])
              held_len[i] <= ({1'b0, held_len[i]} + {1'b0, add_r} > {1'b0, TickMax}) ?
                             TickMax : held_len[i] + add_r;
            else
              rest[i] <= ({1'b0, rest[i]} + {1'b0, add_r} > {1'b0, TickMax}) ?
                         TickMax : rest[i] + add_r;
          end
        end
      end
      if (cmd.flush_init) scan <= '0;
      else if (cmd.flush_step) scan <= scan + TW'(1);
    end
  end

  // Output register: tdata from track up to length_ticks, tuser end_of_song.
  logic [27:0] d28, l28;
  assign d28 = 28'(rest[ev_t[TW-1:0]]);
  assign l28 = 28'(held_len[ev_t[TW-1:0]]);
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {7'd0, l28, d28, held_note[ev_t[TW-1:0]], instr[ev_t[TW-1:0]],
                   pending[ev_t[TW-1:0]], (ev_t == 4'd10) ? 4'd0 : ev_t, ev_t};
      out_last <= out_last_in;
      out_user <= cmd.flush_step;
    end
  end
endmodule

// ===== rtl/msne_controller.sv =====
// Controller: sequences byte intake, command execution, event output and end flush.
`timescale 1ns / 1ps
module msne_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  msne_pkg::dp_status_t status,
  output msne_pkg::dp_cmd_t    cmd,
  output logic                 out_last
);
  msne_pkg::ctrl_state_t state, state_next;
  logic out_full, out_full_next;
  logic room;

  assign room = !out_full || m_axis_tready;
  assign s_axis_tready = state == msne_pkg::ST_IDLE;
  assign m_axis_tvalid = out_full;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_last = 1'b1;
    out_full_next = out_full && !m_axis_tready;
    unique case (state)
      msne_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load_byte = 1'b1;
          state_next = msne_pkg::ST_EXEC;
        end
      end
      msne_pkg::ST_EXEC: begin
        if (!status.is_cmd) state_next = msne_pkg::ST_IDLE;
        else if (status.cmd == msne_pkg::CMD_END) begin
          cmd.flush_init = 1'b1;
          state_next = msne_pkg::ST_FLUSH;
        end else if ((status.cmd == msne_pkg::CMD_PLAY
                      || status.cmd == msne_pkg::CMD_OFF) && status.hit) begin
          if (room) begin
            cmd.out_load = 1'b1;
            out_full_next = 1'b1;
            cmd.exec = 1'b1;
            state_next = msne_pkg::ST_IDLE;
          end
        end else begin
          cmd.exec = 1'b1;
          state_next = msne_pkg::ST_IDLE;
        end
      end
      msne_pkg::ST_FLUSH: begin
        out_last = !status.flush_more;
        if (!status.flush_hit) begin
          cmd.flush_step = 1'b1;
          if (status.flush_last_track || !status.flush_more) state_next = msne_pkg::ST_IDLE;
        end else if (room) begin
          cmd.flush_step = 1'b1;
          cmd.out_load = 1'b1;
          out_full_next = 1'b1;
          if (status.flush_last_track || !status.flush_more) state_next = msne_pkg::ST_IDLE;
        end
      end
      default: state_next = msne_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msne_pkg::ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end
endmodule

// ===== verif/music_sequence_to_note_events_unit_checker.sv =====
// Event predictor and scoreboard for the song sequence decoder.
`timescale 1ns / 1ps
module music_sequence_to_note_events_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending
);
  localparam int unsigned TickMax = (1 << 28) - 1;

  typedef struct packed {
    logic [3:0]  track;
    logic [3:0]  chan;
    logic        pgm;
    logic [7:0]  instr;
    logic [7:0]  note;
    logic [27:0] delay;
    logic [27:0] length;
    logic        eos;
    logic        last;
  } note_event_t;

  note_event_t note_q[$];

  // Song state as the decoder should hold it
  logic [7:0]  mult;
  msne_pkg::phase_t phase;
  int          count;
  int          load_idx;
  logic [3:0]  slot_chan[256];
  logic [7:0]  slot_note[256];
  logic        active[16];
  logic        sounding[16];
  logic [7:0]  held_note[16];
  int unsigned held_len[16];
  int unsigned rest[16];
  logic [7:0]  instr[16];
  logic        pgm_pend[16];
  logic [3:0]  inst_target;

  assign pending = note_q.size();

  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > TickMax) ? TickMax : int'(s);
  endfunction

  task automatic clear_song();
    phase = msne_pkg::PH_COUNT;
    count = 0;
    load_idx = 0;
    inst_target = '0;
    for (int t = 0; t < 16; t++) begin
      active[t] = 1'b0;
      sounding[t] = 1'b0;
      held_note[t] = '0;
      held_len[t] = 0;
      rest[t] = 0;
      instr[t] = '0;
      pgm_pend[t] = 1'b1;
    end
  endtask

  task automatic take_count(int c);
    count = c;
    load_idx = 0;
    phase = (c == 0) ? msne_pkg::PH_CMD : msne_pkg::PH_CHAN;
  endtask

  // Queue the finished note of track t and silence the track
  task automatic finish_note(int t, logic eos);
    note_event_t e;
    e.track = t[3:0];
    e.chan = (t == 10) ? 4'd0 : t[3:0];
    e.pgm = pgm_pend[t];
    e.instr = instr[t];
    e.note = held_note[t];
    e.delay = rest[t][27:0];
    e.length = held_len[t][27:0];
    e.eos = eos;
    e.last = 1'b0;
    note_q.push_back(e);
    pgm_pend[t] = 1'b0;
    rest[t] = 0;
    sounding[t] = 1'b0;
  endtask

  task automatic decode_byte(logic [7:0] b, logic start);
    int n;
    int t;
    int before_len;
    int unsigned add;
    n = count;
    before_len = note_q.size();
    if (start) begin
      clear_song();
      take_count(b);
      return;
    end
    case (phase)
      msne_pkg::PH_COUNT: take_count(b);
      msne_pkg::PH_CHAN: begin
        slot_chan[load_idx] = b[3:0];
        active[b[3:0]] = 1'b1;
        load_idx++;
        if (load_idx >= n) begin
          load_idx = 0;
          phase = msne_pkg::PH_NOTE;
        end
      end
      msne_pkg::PH_NOTE: begin
        slot_note[load_idx] = b;
        load_idx++;
        if (load_idx >= n) begin
          load_idx = 0;
          phase = msne_pkg::PH_CMD;
        end
      end
      msne_pkg::PH_ARG: begin
        if (instr[inst_target] != b) begin
          instr[inst_target] = b;
          pgm_pend[inst_target] = 1'b1;
        end
        phase = msne_pkg::PH_CMD;
      end
      msne_pkg::PH_CMD: begin
        if (b < n) begin
          // play: finish any sounding note on the slot's track
          t = slot_chan[b];
          if (sounding[t]) finish_note(t, 1'b0);
          held_note[t] = slot_note[b] + msne_pkg::NoteOffset;
          sounding[t] = 1'b1;
          held_len[t] = 0;
        end else if (b < n + 16) begin
          t = b - n;
          if (sounding[t]) finish_note(t, 1'b0);
        end else if (b < n + 32) begin
          inst_target = 4'(b - n - 16);
          phase = msne_pkg::PH_ARG;
        end else if (b < msne_pkg::EndCode) begin
          add = (b - (n + 32)) * mult;
          for (t = 0; t < 16; t++) begin
            if (active[t]) begin
              if (sounding[t]) held_len[t] = sat_add(held_len[t], add);
              else rest[t] = sat_add(rest[t], add);
            end
          end
        end else begin
          for (t = 0; t < 16; t++) begin
            if (sounding[t]) finish_note(t, 1'b1);
          end
          phase = msne_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
    if (note_q.size() > before_len) note_q[note_q.size() - 1].last = 1'b1;
  endtask

  // Track configuration writes and input transactions
  always @(posedge clk) begin
    if (rst) begin
      mult = msne_pkg::MultReset;
      clear_song();
      note_q.delete();
    end else begin
      if (cfg_we) mult = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
    end
  end

  // Compare each output transaction with the oldest predicted event
  always @(posedge clk) begin
    note_event_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (note_q.size() == 0) begin
        $error("unexpected event: tdata %h", m_axis_tdata);
        errors <= errors + 1;
      end else begin
        e = note_q.pop_front();
        if (m_axis_tdata[3:0] != e.track ||
            m_axis_tdata[7:4] != e.chan ||
            m_axis_tdata[8] != e.pgm ||
            m_axis_tdata[16:9] != e.instr ||
            m_axis_tdata[24:17] != e.note ||
            m_axis_tdata[52:25] != e.delay ||
            m_axis_tdata[80:53] != e.length ||
            m_axis_tuser != e.eos || m_axis_tlast != e.last)
          errors <= errors + 1;
        if (m_axis_tdata[3:0] != e.track)
          $error("track: expected %0d, got %0d", e.track, m_axis_tdata[3:0]);
        if (m_axis_tdata[7:4] != e.chan)
          $error("note_channel: expected %0d, got %0d", e.chan, m_axis_tdata[7:4]);
        if (m_axis_tdata[8] != e.pgm)
          $error("program_change: expected %0d, got %0d", e.pgm, m_axis_tdata[8]);
        if (m_axis_tdata[16:9] != e.instr)
          $error("instrument: expected %0d, got %0d", e.instr, m_axis_tdata[16:9]);
        if (m_axis_tdata[24:17] != e.note)
          $error("note: expected %0d, got %0d", e.note, m_axis_tdata[24:17]);
        if (m_axis_tdata[52:25] != e.delay)
          $error("delay_ticks: expected %0d, got %0d", e.delay, m_axis_tdata[52:25]);
        if (m_axis_tdata[80:53] != e.length)
          $error("length_ticks: expected %0d, got %0d", e.length, m_axis_tdata[80:53]);
        if (m_axis_tuser != e.eos)
          $error("end_of_song: expected %0d, got %0d", e.eos, m_axis_tuser);
        if (m_axis_tlast != e.last)
          $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
      end
    end
  end

  initial errors = 0;
endmodule

// ===== verif/music_sequence_to_note_events_unit_tb.sv =====
// Stimulus and verdict for the song sequence decoder regression.
`timescale 1ns / 1ps
module music_sequence_to_note_events_unit_tb;
  localparam logic [7:0] RestCode = 8'hFF;
  localparam int FlushWait = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  int          errors;
  int          pending;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;

  always #4 clk = ~clk;

  music_sequence_to_note_events_unit dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  music_sequence_to_note_events_unit_checker chk (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .errors, .pending
  );

  // Stall the event output at random
  always @(posedge clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // Hand one byte to the decoder, idling first at random
  task automatic send_byte(logic [7:0] b, logic start);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Drain all events, let a flush settle, then write the multiplier
  task automatic set_multiplier(logic [7:0] m);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (FlushWait) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One song with random table and mostly well-formed commands
  task automatic play_song();
    int n;
    int cmds;
    int pick;
    n = ($urandom_range(5) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
    if ($urandom_range(9) == 0) n = 0;
    send_byte(n[7:0], 1'b1);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
    cmds = $urandom_range(8, 30);
    for (int i = 0; i < cmds; i++) begin
      pick = $urandom_range(99);
      if (pick < 35 && n > 0) send_byte(8'($urandom_range(n - 1)), 1'b0);
      else if (pick < 50) send_byte(8'(n + $urandom_range(15)), 1'b0);
      else if (pick < 60) begin
        send_byte(8'(n + 16 + $urandom_range(15)), 1'b0);
        send_byte(8'($urandom_range(3) == 0 ? 0 : $urandom), 1'b0);
      end else if (pick < 92) begin
        send_byte(8'(n + 32 + $urandom_range(($urandom_range(3) == 0) ? 221 - n : 6)), 1'b0);
      end else send_byte(8'($urandom_range(msne_pkg::EndCode - 1)), 1'b0);
    end
    // most songs end cleanly; some are cut off by the next start
    if ($urandom_range(5) != 0) begin
      send_byte($urandom_range(1) ? msne_pkg::EndCode : RestCode, 1'b0);
      if ($urandom_range(3) == 0) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int song;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: count taken without start, tracks 10 and 3, note extremes
    send_byte(8'd2, 1'b0);
    send_byte(8'hFA, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2 + 8'd16 + 8'd10, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd2 + 8'd3, 1'b0);
    send_byte(8'd2 + 8'd7, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2 + 8'd16 + 8'd3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'd2 + 8'd33, 1'b0);
    send_byte(RestCode, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'h55, 1'b0);
    // Zero slot count, then one row byte, then end with nothing sounding
    send_byte(8'd0, 1'b1);
    send_byte(8'd32, 1'b0);
    send_byte(msne_pkg::EndCode, 1'b0);

    // Hold off until every event from the directed part is out
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    set_multiplier(8'd1);

    song = 0;
    while (sent < 250) begin
      case (song % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 59; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 59; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      play_song();
      song++;
      if (song % 3 == 0)
        set_multiplier((song % 6 == 0) ? 8'd255 : 8'($urandom_range(1, 255)));
    end

    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (FlushWait) @(posedge clk);
    if (errors == 0) $display("music_sequence_to_note_events_unit regression: pass");
    else $display("music_sequence_to_note_events_unit regression: fail");
    $finish;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("music_sequence_to_note_events_unit regression: fail");
    $finish;
  end
endmodule
